FILE: src/moving_average_adc_filter_assert.svh
// Assertion macros shared by the moving-average filter RTL.
`ifndef MOVING_AVERAGE_ADC_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_ADC_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MAVG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MAVG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mavg_pkg.sv
// Package with constants, types and state codes of the moving-average filter.
package mavg_pkg;

  localparam int unsigned MAX_WINDOW = 15;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned WIN_W      = 4;
  localparam int unsigned CODE_MAX   = (1 << CODE_W) - 1;

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = $clog2(MAX_WINDOW * CODE_MAX + 1);

  // code * 3.3 / 4095 in Q2.14 reduces to code * 90112 / 6825,
  // and 90112 is 11 shifted left by 13.
  localparam int unsigned VOLT_MUL   = 11;
  localparam int unsigned VOLT_SHIFT = 13;
  localparam int unsigned VOLT_DEN   = 6825;

  // A single code is converted by multiplying with the rounded-up reciprocal
  // of 6825, scaled by 2^RAW_SHIFT. The rounding error times any 12-bit code
  // stays below 2^RAW_SHIFT, so the truncated product is exact.
  localparam int unsigned RAW_SHIFT  = 25;
  localparam int unsigned RAW_PROD_W = RAW_SHIFT + VOLT_W;
  localparam logic [RAW_PROD_W-1:0] RAW_RECIP =
    RAW_PROD_W'(((64'(VOLT_MUL) << (VOLT_SHIFT + RAW_SHIFT)) + VOLT_DEN - 1) / VOLT_DEN);

  localparam int unsigned DIVD_W = SUM_W + 4 + VOLT_SHIFT;
  localparam int unsigned DEN_W  = $clog2(VOLT_DEN * MAX_WINDOW + 1);
  localparam int unsigned QUO_W  = VOLT_W;
  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AVG_MODE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_AVG,
    ST_DONE
  } mavg_state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/mavg_in_if.sv
// Input sample channel: converter code and frame start flag.
interface mavg_in_if;
  logic                             valid;
  logic                             ready;
  logic [mavg_pkg::CODE_W-1:0]      adc_code;
  logic                             frame_start;

  modport source (output valid, output adc_code, output frame_start, input ready);
  modport sink (input valid, input adc_code, input frame_start, output ready);
endinterface

FILE: src/mavg_out_if.sv
// Result channel: raw and filtered voltages.
interface mavg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mavg_pkg::VOLT_W-1:0] raw_volts;
  logic [mavg_pkg::VOLT_W-1:0] filtered_volts;

  modport source (output valid, output raw_volts, output filtered_volts, input ready);
  modport sink (input valid, input raw_volts, input filtered_volts, output ready);
endinterface

FILE: src/mavg_cfg_if.sv
// Configuration write channel: register index and write data.
interface mavg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mavg_pkg::CFG_IDX_W-1:0]  index;
  logic [mavg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/mavg_ram.sv
// Generic one-write, one-read synchronous RAM with registered read data.
module mavg_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mavg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module mavg_div (
  input  logic               clk,
  input  logic               rst,
  input  mavg_pkg::div_req_t req,
  output mavg_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [mavg_pkg::STEP_W-1:0]       steps;
  logic [mavg_pkg::DEN_W-1:0]        rem;
  logic [mavg_pkg::DEN_W-1:0]        rem_next;
  logic [mavg_pkg::DEN_W-1:0]        den;
  logic [mavg_pkg::QUO_W-1:0]        quo;
  logic [mavg_pkg::DEN_W:0]          rem_shift;
  logic                              fits;

  // The quotient is known to fit QUO_W bits, so the upper dividend bits
  // start out below the divisor and the remainder never needs more width.
  always_comb begin
    rem_shift = {rem, quo[mavg_pkg::QUO_W-1]};
    fits      = rem_shift >= {1'b0, den};
    rem_next  = fits ? mavg_pkg::DEN_W'(rem_shift - {1'b0, den})
                     : mavg_pkg::DEN_W'(rem_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= mavg_pkg::STEP_W'(mavg_pkg::QUO_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == mavg_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= mavg_pkg::DEN_W'(req.dividend >> mavg_pkg::QUO_W);
      quo <= req.dividend[mavg_pkg::QUO_W-1:0];
      den <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[mavg_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: src/moving_average_adc_filter.sv
// Moving-average ADC filter: sample history in RAM, serial summation and division.
//
// Usage: samples arrive on the sample channel (adc_code, frame_start) and one
// result per sample leaves on the result channel (raw_volts, filtered_volts),
// both as valid/ready transfers. Configuration writes on the cfg channel set
// the averaging mode (index 0) and window_length (index 1); cfg is always
// ready, and the user must write it only while no sample is in flight: the
// block itself does not enforce this. Each accepted sample is written into a
// ring buffer RAM and converted to volts by a reciprocal multiplication; the
// older samples of the window are then read back one per cycle and summed, and
// in average mode a 16-step serial divider turns the sum into the averaged
// voltage. A new sample is taken only after the result of the previous one has
// been loaded into the output register; the block turns ready again in the
// cycle its result becomes valid. The sum is formed in bypass as well.
// The result sits in an output register, so the next sample is accepted while
// a result waits; only when a second result is done while the first is still
// stalled does the block hold off further samples.
// Reset clears the pointer, fill count and output valid, selects bypass and a
// window of 5; no frame start is needed after reset.
module moving_average_adc_filter (
  input  logic       clk,
  input  logic       rst,
  mavg_in_if.sink    sample,
  mavg_out_if.source result,
  mavg_cfg_if.sink   cfg
);

  `include "moving_average_adc_filter_assert.svh"

  mavg_pkg::mavg_state_t state;
  mavg_pkg::mavg_state_t state_next;

  logic                         mode;
  logic [mavg_pkg::WIN_W-1:0]   win;
  logic [mavg_pkg::PTR_W-1:0]   ptr;
  logic [mavg_pkg::CNT_W-1:0]   count;
  logic [mavg_pkg::SUM_W-1:0]   sum;
  logic [mavg_pkg::CNT_W-1:0]   n_q;
  logic [mavg_pkg::CNT_W-1:0]   left;
  logic [mavg_pkg::PTR_W-1:0]   rd_addr;
  logic                         rd_vld;
  logic [mavg_pkg::VOLT_W-1:0]  raw_q;
  logic [mavg_pkg::VOLT_W-1:0]  avg_q;
  logic                         out_valid;
  logic [mavg_pkg::VOLT_W-1:0]  out_raw;
  logic [mavg_pkg::VOLT_W-1:0]  out_filt;

  logic                         accept;
  logic                         rd_en;
  logic                         out_load;
  logic                         sum_done;
  logic [mavg_pkg::PTR_W-1:0]   base_ptr;
  logic [mavg_pkg::CNT_W-1:0]   base_cnt;
  logic [mavg_pkg::PTR_W-1:0]   new_ptr;
  logic [mavg_pkg::CNT_W-1:0]   new_cnt;
  logic [mavg_pkg::CNT_W-1:0]   win_eff;
  logic [mavg_pkg::CNT_W-1:0]   n_new;
  logic [mavg_pkg::PTR_W-1:0]   prev_base;
  logic [mavg_pkg::PTR_W-1:0]   prev_rd;
  logic [mavg_pkg::CODE_W-1:0]  rd_data;
  logic [mavg_pkg::RAW_PROD_W-1:0] raw_prod;

  mavg_pkg::div_req_t div_req;
  mavg_pkg::div_rsp_t div_rsp;

  mavg_ram #(
    .DEPTH (mavg_pkg::MAX_WINDOW),
    .WIDTH (mavg_pkg::CODE_W)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (base_ptr),
    .wdata (sample.adc_code),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mavg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Ring pointer and fill count as seen by the incoming sample.
  always_comb begin
    base_ptr = sample.frame_start ? '0 : ptr;
    base_cnt = sample.frame_start ? '0 : count;
    new_ptr  = (base_ptr == mavg_pkg::PTR_W'(mavg_pkg::MAX_WINDOW - 1))
               ? '0 : base_ptr + 1'b1;
    new_cnt  = (32'(base_cnt) < mavg_pkg::MAX_WINDOW) ? base_cnt + 1'b1 : base_cnt;
    if (win == '0) begin
      win_eff = mavg_pkg::CNT_W'(1);
    end else if (32'(win) > mavg_pkg::MAX_WINDOW) begin
      win_eff = mavg_pkg::CNT_W'(mavg_pkg::MAX_WINDOW);
    end else begin
      win_eff = mavg_pkg::CNT_W'(win);
    end
    n_new     = (new_cnt < win_eff) ? new_cnt : win_eff;
    prev_base = (base_ptr == '0) ? mavg_pkg::PTR_W'(mavg_pkg::MAX_WINDOW - 1)
                                 : base_ptr - 1'b1;
    prev_rd   = (rd_addr == '0) ? mavg_pkg::PTR_W'(mavg_pkg::MAX_WINDOW - 1)
                                : rd_addr - 1'b1;
    raw_prod  = mavg_pkg::RAW_PROD_W'(sample.adc_code) * mavg_pkg::RAW_RECIP;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mavg_pkg::ST_IDLE: begin
        if (sample.valid) begin
          state_next = mavg_pkg::ST_SUM;
        end
      end
      mavg_pkg::ST_SUM: begin
        if (left == '0 && !rd_vld) begin
          state_next = mode ? mavg_pkg::ST_DIV_AVG : mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DIV_AVG: begin
        if (div_rsp.done) begin
          state_next = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = mavg_pkg::ST_IDLE;
        end
      end
      default: state_next = mavg_pkg::ST_IDLE;
    endcase
  end

  // The RAM is written only at acceptance and read only while summing, and
  // the reads never touch the slot just written, so no forwarding is needed.
  always_comb begin
    sample.ready = (state == mavg_pkg::ST_IDLE);
    cfg.ready    = 1'b1;
    accept       = (state == mavg_pkg::ST_IDLE) && sample.valid;
    rd_en        = (state == mavg_pkg::ST_SUM) && (left != '0);
    sum_done     = (state == mavg_pkg::ST_SUM) && (left == '0) && !rd_vld;
    out_load     = (state == mavg_pkg::ST_DONE) && (!out_valid || result.ready);
    div_req.start    = sum_done && mode;
    div_req.dividend = mavg_pkg::DIVD_W'(sum * mavg_pkg::VOLT_MUL)
                       << mavg_pkg::VOLT_SHIFT;
    div_req.divisor  = mavg_pkg::DEN_W'(mavg_pkg::VOLT_DEN * n_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mavg_pkg::ST_IDLE;
      mode      <= 1'b0;
      win       <= mavg_pkg::WINDOW_RESET;
      ptr       <= '0;
      count     <= '0;
      left      <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (cfg.valid) begin
        priority if (cfg.index == mavg_pkg::REG_AVG_MODE) begin
          mode <= cfg.data[0];
        end else if (cfg.index == mavg_pkg::REG_WINDOW_LENGTH) begin
          win <= cfg.data[mavg_pkg::WIN_W-1:0];
        end
      end
      if (accept) begin
        ptr   <= new_ptr;
        count <= new_cnt;
        left  <= n_new - 1'b1;
      end else if (rd_en) begin
        left <= left - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_q   <= raw_prod[mavg_pkg::RAW_SHIFT +: mavg_pkg::VOLT_W];
      n_q     <= n_new;
      sum     <= mavg_pkg::SUM_W'(sample.adc_code);
      rd_addr <= prev_base;
    end else begin
      if (rd_en) begin
        rd_addr <= prev_rd;
      end
      if (rd_vld) begin
        sum <= sum + mavg_pkg::SUM_W'(rd_data);
      end
    end
    if (div_rsp.done && state == mavg_pkg::ST_DIV_AVG) begin
      avg_q <= div_rsp.quotient;
    end
    if (out_load) begin
      out_raw  <= raw_q;
      out_filt <= mode ? avg_q : raw_q;
    end
  end

  assign result.valid          = out_valid;
  assign result.raw_volts      = out_raw;
  assign result.filtered_volts = out_filt;

  `MAVG_ASSERT_NXT(a_accept_starts_sum, sample.valid && sample.ready,
                   state == mavg_pkg::ST_SUM && count != '0,
                   "accepted sample did not start summation with a nonzero fill count")
  `MAVG_ASSERT_IMP(a_sum_bounds, state == mavg_pkg::ST_SUM,
                   n_q != '0 && n_q <= count && left < n_q,
                   "averaging span exceeds the samples held in this frame")
  `MAVG_ASSERT_IMP(a_div_done_owner, div_rsp.done,
                   state == mavg_pkg::ST_DIV_AVG,
                   "divider finished while no conversion was pending")

endmodule
